### src/rfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and the CRC byte update for the frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int FRAME_BYTES  = 64;
    localparam int STORE_DEPTH  = FRAME_BYTES - 3;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int IDX_W        = $clog2(STORE_DEPTH);
    localparam int RAM_AW       = IDX_W + 1;
    localparam int RAM_DEPTH    = 2 * (1 << IDX_W);
    localparam int CMP_W        = 9;

    localparam logic [15:0] CRC_POLY  = 16'h8005;
    localparam logic [7:0]  COUNT_MIN = 8'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_COUNT = 2'd1,
        ST_BAD_CRC   = 2'd2
    } status_t;

    // One finished frame, handed from the front end to the back end.
    typedef struct packed {
        status_t    status;
        logic [7:0] kept;
        logic       bank;
    } frame_desc_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } ram_wr_t;

    // Bytes enter the CRC least significant bit first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            if (b[i] != c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### src/response_frame_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// response_frame_checker
// Checks fixed-length response frames (count, payload, CRC-16 0x8005) and
// plays out the kept payload or a single closing word per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one frame word per cycle:
//   rx_byte, frame_start marking the count word, keep_limit sampled with it.
//   Words outside a frame are dropped; frame_start inside a frame restarts.
//   Output channel (out_valid / out_stall) gives one result word per cycle.
//   An error or empty-payload word passes the descriptor queue and output
//   register after the last frame word is taken; the first payload word
//   also the RAM read register, the rest follow one per cycle. The CRC is
//   updated a whole byte per cycle, so the input takes one word per cycle.
//   Payload sits in a two-bank RAM; in_stall rises while two finished frames
//   still wait to be played out, and drops when the older one is done.
//   A stalled output word holds; the back end then waits, and the front end
//   keeps taking words until the second bank is also waiting.
//   Reset clears all control state; no clearing pass is needed, the RAM
//   is only read where the same frame wrote it.
// ----------------------------------------------------------------------------
module response_frame_checker
    import rfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    input  wire logic [7:0]  keep_limit,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       payload_byte,
    output logic             payload_valid,
    output logic [1:0]       frame_status,
    output logic [7:0]       kept_length,
    output logic             last_of_frame
);

    ram_wr_t           ram_wr;
    logic              push_valid;
    frame_desc_t       push_desc;
    logic              frame_done;
    logic              q_valid;
    frame_desc_t       q_desc;
    logic              q_pop;
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    rfc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .keep_limit  (keep_limit),
        .ram_wr      (ram_wr),
        .push_valid  (push_valid),
        .push_desc   (push_desc),
        .frame_done  (frame_done)
    );

    rfc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_desc  (push_desc),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (q_desc)
    );

    rfc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_desc        (q_desc),
        .q_pop         (q_pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .frame_done    (frame_done),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .frame_status  (frame_status),
        .kept_length   (kept_length),
        .last_of_frame (last_of_frame)
    );

endmodule
`default_nettype wire

### src/rfc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### src/rfc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_front
// Takes frame words, runs the CRC, writes payload into the current RAM bank
// and posts a frame descriptor when the last frame word arrives.
// ----------------------------------------------------------------------------
module rfc_front
    import rfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    input  wire logic [7:0]  keep_limit,
    output ram_wr_t          ram_wr,
    output logic             push_valid,
    output frame_desc_t      push_desc,
    input  wire logic        frame_done
);

    logic [15:0]      crc_reg, crc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       low_reg, low_next;
    logic [7:0]       limit_reg, limit_next;
    logic             active_reg, active_next;
    logic             bank_reg, bank_next;
    logic [1:0]       pend_reg, pend_next;

    logic             accept;
    logic [POS_W-1:0] p_eff;
    logic [15:0]      crc_eff;
    logic [7:0]       low_eff;
    logic [7:0]       limit_eff;
    logic             active_eff;
    logic [7:0]       cnt;
    logic             count_ok;
    logic [CMP_W-1:0] p9;
    logic [CMP_W-1:0] cnt9;
    logic             last_word;
    logic [7:0]       payload_len;
    logic [POS_W-1:0] store_idx;

    // Two banks in the RAM, so at most two finished frames may wait on the back end.
    assign in_stall = (pend_reg == 2'd2);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        p_eff      = frame_start ? '0 : pos_reg;
        crc_eff    = frame_start ? 16'h0000 : crc_reg;
        low_eff    = frame_start ? 8'h00 : low_reg;
        limit_eff  = frame_start ? keep_limit : limit_reg;
        active_eff = frame_start || active_reg;
        cnt        = (p_eff == '0) ? rx_byte : count_reg;
        p9         = CMP_W'(p_eff);
        cnt9       = CMP_W'(cnt);
        count_ok   = (cnt >= COUNT_MIN) && (cnt9 <= CMP_W'(FRAME_BYTES));
        last_word  = (p_eff == POS_W'(FRAME_BYTES - 1));
        store_idx  = p_eff - POS_W'(1);

        crc_next    = crc_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        low_next    = low_reg;
        limit_next  = limit_reg;
        active_next = active_reg;
        bank_next   = bank_reg;

        ram_wr.en   = 1'b0;
        ram_wr.addr = {bank_reg, store_idx[IDX_W-1:0]};
        ram_wr.data = rx_byte;

        push_valid       = 1'b0;
        push_desc.status = ST_OK;
        push_desc.kept   = 8'd0;
        push_desc.bank   = bank_reg;

        if (accept && active_eff)
        begin
            crc_next    = crc_eff;
            low_next    = low_eff;
            limit_next  = limit_eff;
            count_next  = cnt;
            active_next = 1'b1;

            if (count_ok)
            begin
                if (p9 < cnt9 - CMP_W'(2))
                begin
                    crc_next = crc_feed(crc_eff, rx_byte);
                    if (p_eff != '0)
                    begin
                        ram_wr.en = 1'b1;
                    end
                end
                else if (p9 == cnt9 - CMP_W'(2))
                begin
                    low_next = rx_byte;
                end
                else if (p9 == cnt9 - CMP_W'(1))
                begin
                    // A matching received CRC leaves zero behind.
                    crc_next = crc_eff ^ {rx_byte, low_eff};
                end
            end

            if (last_word)
            begin
                active_next = 1'b0;
                pos_next    = '0;
                bank_next   = !bank_reg;
                push_valid  = 1'b1;
                payload_len = cnt - 8'd3;
                if (!count_ok)
                begin
                    push_desc.status = ST_BAD_COUNT;
                end
                else if (crc_next != 16'h0000)
                begin
                    push_desc.status = ST_BAD_CRC;
                end
                else
                begin
                    push_desc.kept = (payload_len > limit_eff) ? limit_eff : payload_len;
                end
            end
            else
            begin
                pos_next = p_eff + POS_W'(1);
            end
        end

        payload_len = cnt - 8'd3;
        pend_next   = pend_reg + {1'b0, push_valid} - {1'b0, frame_done};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= 16'h0000;
            pos_reg    <= '0;
            count_reg  <= 8'd0;
            low_reg    <= 8'd0;
            limit_reg  <= 8'd0;
            active_reg <= 1'b0;
            bank_reg   <= 1'b0;
            pend_reg   <= 2'd0;
        end
        else
        begin
            crc_reg    <= crc_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            low_reg    <= low_next;
            limit_reg  <= limit_next;
            active_reg <= active_next;
            bank_reg   <= bank_next;
            pend_reg   <= pend_next;
        end
    end

endmodule
`default_nettype wire

### src/rfc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_queue
// Two-entry queue of frame descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module rfc_queue
    import rfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire frame_desc_t push_desc,
    input  wire logic        pop,
    output logic             head_valid,
    output frame_desc_t      head_desc
);

    frame_desc_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        do_push;
    logic        do_pop;

    assign head_valid = (fill_reg != 2'd0);
    assign head_desc  = slot_reg[rd_ptr_reg];
    assign do_push    = push && (fill_reg != 2'd2);
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule
`default_nettype wire

### src/rfc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_back
// Takes frame descriptors and plays out the result words of each frame,
// reading kept payload from the RAM bank named in the descriptor.
// ----------------------------------------------------------------------------
module rfc_back
    import rfc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire frame_desc_t       q_desc,
    output logic                   q_pop,
    output logic                   rd_en,
    output logic [RAM_AW-1:0]      rd_addr,
    input  wire logic [7:0]        rd_data,
    output logic                   frame_done,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             payload_byte,
    output logic                   payload_valid,
    output logic [1:0]             frame_status,
    output logic [7:0]             kept_length,
    output logic                   last_of_frame
);

    typedef enum logic {
        S_IDLE,
        S_PLAY
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       kept_reg, kept_next;
    logic             bank_reg, bank_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             pvalid_reg, pvalid_next;
    status_t          status_reg, status_next;
    logic [7:0]       klen_reg, klen_next;
    logic             last_reg, last_next;
    logic             out_free;
    logic             at_end;

    assign out_free      = !out_valid_reg || !out_stall;
    assign at_end        = (8'(idx_reg) == kept_reg - 8'd1);
    assign out_valid     = out_valid_reg;
    assign payload_byte  = byte_reg;
    assign payload_valid = pvalid_reg;
    assign frame_status  = status_reg;
    assign kept_length   = klen_reg;
    assign last_of_frame = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        bank_next      = bank_reg;
        out_valid_next = out_valid_reg && out_stall;
        byte_next      = byte_reg;
        pvalid_next    = pvalid_reg;
        status_next    = status_reg;
        klen_next      = klen_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = {bank_reg, idx_reg};
        frame_done     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if ((q_desc.status != ST_OK) || (q_desc.kept == 8'd0))
                    begin
                        // Errors and empty frames give a single closing word.
                        if (out_free)
                        begin
                            q_pop          = 1'b1;
                            frame_done     = 1'b1;
                            out_valid_next = 1'b1;
                            byte_next      = 8'd0;
                            pvalid_next    = 1'b0;
                            status_next    = q_desc.status;
                            klen_next      = 8'd0;
                            last_next      = 1'b1;
                        end
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        kept_next  = q_desc.kept;
                        bank_next  = q_desc.bank;
                        idx_next   = '0;
                        rd_en      = 1'b1;
                        rd_addr    = {q_desc.bank, {IDX_W{1'b0}}};
                        state_next = S_PLAY;
                    end
                end
            end
            S_PLAY:
            begin
                // rd_data holds the entry at idx_reg until the next read is issued.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    byte_next      = rd_data;
                    pvalid_next    = 1'b1;
                    status_next    = ST_OK;
                    klen_next      = kept_reg;
                    last_next      = at_end;
                    if (at_end)
                    begin
                        frame_done = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = {bank_reg, idx_reg + IDX_W'(1)};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            kept_reg      <= 8'd0;
            bank_reg      <= 1'b0;
            byte_reg      <= 8'd0;
            pvalid_reg    <= 1'b0;
            status_reg    <= ST_OK;
            klen_reg      <= 8'd0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            kept_reg      <= kept_next;
            bank_reg      <= bank_next;
            byte_reg      <= byte_next;
            pvalid_reg    <= pvalid_next;
            status_reg    <= status_next;
            klen_reg      <= klen_next;
            last_reg      <= last_next;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLAY) |-> (8'(idx_reg) < kept_reg))
        else $error("payload index beyond kept length");

    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (out_valid_reg && last_reg))
        else $error("frame finished without a closing word");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |->
            (!pvalid_reg && (klen_reg == 8'd0) && last_reg && (byte_reg == 8'd0)))
        else $error("error word carries payload");
`endif

endmodule
`default_nettype wire
